/* hw/rtl/fbpa_pkg.sv */
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and controller interface types for the fixed-size
// block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int KIND_W      = 1;
    localparam int SIZE_W      = 16;
    localparam int ADDR_W      = 20;
    localparam int STATUS_W    = 3;
    localparam int BS_W        = 11;
    localparam int BPB_W       = 7;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int BSIZE_W     = 12;
    localparam int SIZE_ALIGN  = 16;
    localparam int ADDR_SPACE  = 1 << ADDR_W;

    localparam logic [BS_W-1:0]  BLOCK_SIZE_RESET    = 11'd16;
    localparam logic [BPB_W-1:0] BUFFER_BLOCKS_RESET = 7'd4;

    localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_BLOCKS = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_EXHAUSTED   = 3'd2,
        ST_DOUBLE_FREE = 3'd3,
        ST_FOREIGN     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEOM,
        S_CHECK,
        S_GROW,
        S_POP,
        S_POP_TAKE,
        S_MUL,
        S_SUM,
        S_DIV_K,
        S_LOAD_S,
        S_DIV_S,
        S_MAP_READ,
        S_FREE_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    geom;
        logic    div_load_k;
        logic    div_step;
        logic    load_s;
        logic    grow_push;
        logic    pop;
        logic    pop_take;
        logic    mul;
        logic    sum;
        logic    map_read;
        logic    free_push;
        logic    set_status;
        status_t status_code;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic is_free_op;
        logic too_large;
        logic stack_empty;
        logic pool_full;
        logic foreign;
        logic grow_last;
        logic div_last;
        logic misaligned;
        logic block_free;
        logic out_ready;
    } stat_t;

endpackage

/* hw/rtl/fbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer for the allocator: walks one request at a time through pool
// growth, stack pop and address build, or through the free-address divider
// and free-map check.
// ----------------------------------------------------------------------------
module fbpa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  fbpa_pkg::stat_t stat,
    output fbpa_pkg::cmd_t  cmd
);
    import fbpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_GEOM;
                end
            end
            S_GEOM:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.is_free_op)
                begin
                    state_next = stat.foreign ? S_DONE : S_DIV_K;
                end
                else if (stat.too_large)
                begin
                    state_next = S_DONE;
                end
                else if (stat.stack_empty)
                begin
                    state_next = stat.pool_full ? S_DONE : S_GROW;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_GROW:
            begin
                if (stat.grow_last)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = S_POP_TAKE;
            end
            S_POP_TAKE:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_DONE;
            end
            S_DIV_K:
            begin
                if (stat.div_last)
                begin
                    state_next = S_LOAD_S;
                end
            end
            S_LOAD_S:
            begin
                state_next = S_DIV_S;
            end
            S_DIV_S:
            begin
                if (stat.div_last)
                begin
                    state_next = S_MAP_READ;
                end
            end
            S_MAP_READ:
            begin
                state_next = stat.misaligned ? S_DONE : S_FREE_CHECK;
            end
            S_FREE_CHECK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.status_code = ST_OK;
        in_stall        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_GEOM:
            begin
                cmd.geom = 1'b1;
            end
            S_CHECK:
            begin
                if (stat.is_free_op)
                begin
                    if (stat.foreign)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_FOREIGN;
                    end
                    else
                    begin
                        cmd.div_load_k = 1'b1;
                    end
                end
                else if (stat.too_large)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_TOO_LARGE;
                end
                else if (stat.stack_empty && stat.pool_full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_EXHAUSTED;
                end
            end
            S_GROW:
            begin
                cmd.grow_push = 1'b1;
            end
            S_POP:
            begin
                cmd.pop = 1'b1;
            end
            S_POP_TAKE:
            begin
                cmd.pop_take = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            S_SUM:
            begin
                cmd.sum         = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_OK;
            end
            S_DIV_K:
            begin
                cmd.div_step = 1'b1;
            end
            S_LOAD_S:
            begin
                cmd.load_s = 1'b1;
            end
            S_DIV_S:
            begin
                cmd.div_step = 1'b1;
            end
            S_MAP_READ:
            begin
                if (stat.misaligned)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FOREIGN;
                end
                else
                begin
                    cmd.map_read = 1'b1;
                end
            end
            S_FREE_CHECK:
            begin
                cmd.set_status = 1'b1;
                if (stat.block_free)
                begin
                    cmd.status_code = ST_DOUBLE_FREE;
                end
                else
                begin
                    cmd.free_push   = 1'b1;
                    cmd.status_code = ST_OK;
                end
            end
            S_DONE:
            begin
                cmd.emit = stat.out_ready;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* hw/rtl/fbpa_datapath.sv */
// ----------------------------------------------------------------------------
// fbpa_datapath
// Configuration registers, free stack and free map memories, pool growth
// counters, shared restoring divider and result registers of the allocator.
// ----------------------------------------------------------------------------
module fbpa_datapath
#(
    parameter int MAX_BUFFERS       = 16,
    parameter int MAX_BUFFER_BLOCKS = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [fbpa_pkg::KIND_W-1:0]        kind,
    input  logic [fbpa_pkg::SIZE_W-1:0]        alloc_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]        block_address,
    input  fbpa_pkg::cmd_t                     cmd,
    output fbpa_pkg::stat_t                    stat,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [fbpa_pkg::STATUS_W-1:0]      status,
    output logic [fbpa_pkg::ADDR_W-1:0]        granted_address
);
    import fbpa_pkg::*;

    localparam int POOL_BLOCKS = MAX_BUFFERS * MAX_BUFFER_BLOCKS;
    localparam int KW      = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int SW      = (MAX_BUFFER_BLOCKS > 1) ? $clog2(MAX_BUFFER_BLOCKS) : 1;
    localparam int EW      = KW + SW;
    localparam int SAW     = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
    localparam int CW      = $clog2(POOL_BLOCKS + 1);
    localparam int BW      = $clog2(MAX_BUFFERS + 1);
    localparam int PW      = $clog2(MAX_BUFFER_BLOCKS + 1);
    localparam int BUFSZ_W = BSIZE_W + PW;
    localparam int BASE_W  = ADDR_W + 1;
    localparam int END_W   = BASE_W + 1;
    localparam int QW      = (KW > SW) ? KW : SW;
    localparam int QCW     = (QW > 1) ? $clog2(QW) : 1;
    localparam int DVK_W   = BUFSZ_W + KW - 1;
    localparam int DVS_W   = BSIZE_W + SW - 1;
    localparam int DV_A    = (DVK_W > DVS_W) ? DVK_W : DVS_W;
    localparam int DV_W    = (DV_A > ADDR_W) ? DV_A : ADDR_W;
    localparam int PA_W    = KW + BUFSZ_W;
    localparam int PB_W    = SW + BSIZE_W;
    localparam int SUM_A   = (PA_W > PB_W) ? PA_W : PB_W;
    localparam int SUM_W   = ((SUM_A > ADDR_W) ? SUM_A : ADDR_W) + 1;

    function automatic logic [SAW-1:0] map_index(input logic [KW-1:0] k,
                                                 input logic [SW-1:0] s);
        return SAW'(k) * SAW'(MAX_BUFFER_BLOCKS) + SAW'(s);
    endfunction

    logic [BS_W-1:0]    block_size_reg;
    logic [BPB_W-1:0]   bpb_reg;

    logic [KIND_W-1:0]  kind_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic [BSIZE_W-1:0] bsize_reg;
    logic [PW-1:0]      per_reg;
    logic [BUFSZ_W-1:0] bufsize_reg;

    logic [EW-1:0]      stack_mem [POOL_BLOCKS];
    logic [EW-1:0]      stack_q;
    logic               map_mem [POOL_BLOCKS];
    logic               map_q;

    logic [CW-1:0]      count_reg;
    logic [BW-1:0]      biu_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [SW-1:0]      slot_reg;
    logic [QCW-1:0]     qcnt_reg;

    logic [ADDR_W-1:0]  rem_reg;
    logic [DV_W-1:0]    dvs_reg;
    logic [QW-1:0]      q_reg;
    logic [KW-1:0]      k_reg;
    logic [SW-1:0]      s_reg;
    logic [PA_W-1:0]    prod_a_reg;
    logic [PB_W-1:0]    prod_b_reg;
    logic [ADDR_W-1:0]  granted_reg;
    status_t            status_reg;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [ADDR_W-1:0]  out_granted_reg;

    logic [BS_W-1:0]    bs_v;
    logic [BSIZE_W-1:0] bsize_sum;
    logic [BSIZE_W-1:0] bsize_c;
    logic [PW-1:0]      per_c;
    logic [BUFSZ_W-1:0] bufsize_c;
    logic [END_W-1:0]   end_c;
    logic [CW-1:0]      count_dec;
    logic               ge;
    logic [QW:0]        q_shift;
    logic [SUM_W-1:0]   sum_c;
    logic [KW-1:0]      pop_k;
    logic [SW-1:0]      pop_s;

    // Effective geometry from the configuration registers.
    always_comb
    begin
        bs_v      = (block_size_reg == '0) ? BS_W'(1) : block_size_reg;
        bsize_sum = BSIZE_W'(bs_v) + BSIZE_W'(SIZE_ALIGN - 1);
        bsize_c   = bsize_sum & ~BSIZE_W'(SIZE_ALIGN - 1);
        if (bpb_reg == '0)
        begin
            per_c = PW'(1);
        end
        else if (32'(bpb_reg) > MAX_BUFFER_BLOCKS)
        begin
            per_c = PW'(MAX_BUFFER_BLOCKS);
        end
        else
        begin
            per_c = PW'(bpb_reg);
        end
        bufsize_c = BUFSZ_W'(bsize_c) * BUFSZ_W'(per_c);
    end

    assign end_c     = END_W'(base_reg) + END_W'(bufsize_reg);
    assign count_dec = count_reg - CW'(1);
    assign ge        = (DV_W'(rem_reg) >= dvs_reg);
    assign q_shift   = {q_reg, ge};
    assign sum_c     = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg);
    assign pop_k     = stack_q[EW-1:SW];
    assign pop_s     = stack_q[SW-1:0];

    always_comb
    begin
        stat.is_free_op  = (kind_reg == KIND_FREE);
        stat.too_large   = (size_reg > SIZE_W'(bsize_reg));
        stat.stack_empty = (count_reg == '0);
        stat.pool_full   = (biu_reg >= BW'(MAX_BUFFERS)) || (end_c > END_W'(ADDR_SPACE));
        stat.foreign     = (BASE_W'(addr_reg) >= base_reg);
        stat.grow_last   = ((PW'(slot_reg) + PW'(1)) == per_reg);
        stat.div_last    = (qcnt_reg == '0);
        stat.misaligned  = (rem_reg != '0);
        stat.block_free  = map_q;
        stat.out_ready   = !out_valid_reg || !out_stall;
    end

    // The geometry locks once the first buffer has been added.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
            bpb_reg        <= BUFFER_BLOCKS_RESET;
        end
        else if (cfg_write && (biu_reg == '0))
        begin
            case (cfg_index)
                CFG_BLOCK_SIZE:
                begin
                    block_size_reg <= cfg_data[BS_W-1:0];
                end
                CFG_BUFFER_BLOCKS:
                begin
                    bpb_reg <= cfg_data[BPB_W-1:0];
                end
                default:
                begin
                    block_size_reg <= block_size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            biu_reg       <= '0;
            base_reg      <= '0;
            slot_reg      <= '0;
            qcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.grow_push || cmd.free_push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_dec;
            end

            if (cmd.grow_push)
            begin
                if (stat.grow_last)
                begin
                    slot_reg <= '0;
                    biu_reg  <= biu_reg + BW'(1);
                    base_reg <= base_reg + BASE_W'(bufsize_reg);
                end
                else
                begin
                    slot_reg <= slot_reg + SW'(1);
                end
            end

            if (cmd.div_load_k)
            begin
                qcnt_reg <= QCW'(KW - 1);
            end
            else if (cmd.load_s)
            begin
                qcnt_reg <= QCW'(SW - 1);
            end
            else if (cmd.div_step)
            begin
                qcnt_reg <= qcnt_reg - QCW'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grow_push)
        begin
            stack_mem[count_reg[SAW-1:0]] <= {biu_reg[KW-1:0], slot_reg};
        end
        else if (cmd.free_push)
        begin
            stack_mem[count_reg[SAW-1:0]] <= {k_reg, s_reg};
        end
        if (cmd.pop)
        begin
            stack_q <= stack_mem[count_dec[SAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.grow_push)
        begin
            map_mem[map_index(biu_reg[KW-1:0], slot_reg)] <= 1'b1;
        end
        else if (cmd.free_push)
        begin
            map_mem[map_index(k_reg, s_reg)] <= 1'b1;
        end
        else if (cmd.pop_take)
        begin
            map_mem[map_index(pop_k, pop_s)] <= 1'b0;
        end
        if (cmd.map_read)
        begin
            map_q <= map_mem[map_index(k_reg, q_reg[SW-1:0])];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            size_reg    <= alloc_size;
            addr_reg    <= block_address;
            granted_reg <= '0;
        end
        else if (cmd.sum)
        begin
            granted_reg <= sum_c[ADDR_W-1:0];
        end

        if (cmd.geom)
        begin
            bsize_reg   <= bsize_c;
            per_reg     <= per_c;
            bufsize_reg <= bufsize_c;
        end

        // One quotient bit per cycle: buffer number first, then block slot.
        if (cmd.div_load_k)
        begin
            rem_reg <= addr_reg;
            dvs_reg <= DV_W'(bufsize_reg) << (KW - 1);
            q_reg   <= '0;
        end
        else if (cmd.load_s)
        begin
            k_reg   <= q_reg[KW-1:0];
            dvs_reg <= DV_W'(bsize_reg) << (SW - 1);
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dvs_reg[ADDR_W-1:0];
            end
            q_reg   <= q_shift[QW-1:0];
            dvs_reg <= dvs_reg >> 1;
        end
        else if (cmd.pop_take)
        begin
            k_reg <= pop_k;
        end

        if (cmd.map_read)
        begin
            s_reg <= q_reg[SW-1:0];
        end
        else if (cmd.pop_take)
        begin
            s_reg <= pop_s;
        end

        if (cmd.mul)
        begin
            prod_a_reg <= PA_W'(k_reg) * PA_W'(bufsize_reg);
            prod_b_reg <= PB_W'(s_reg) * PB_W'(bsize_reg);
        end

        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end

        if (cmd.emit)
        begin
            out_status_reg  <= status_reg;
            out_granted_reg <= granted_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign granted_address = out_granted_reg;

endmodule

/* hw/rtl/fixed_block_pool_allocator_top.sv */
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool allocator with a last-in first-out free stack. It
// handles one request at a time. An allocation served from a non-empty stack
// passes through the geometry, check, pop, pop-take, multiply and sum states
// before its result is offered; when the stack is empty the pool first grows
// by one buffer, pushing one block per cycle. A free runs a restoring divider
// one quotient bit per cycle, clog2(MAX_BUFFERS) + clog2(MAX_BUFFER_BLOCKS)
// steps, then checks the free map unless the address is off a block boundary.
// A request that is too large, finds the pool exhausted or frees an address
// outside the pool returns straight from the check state. While the output
// stalls, a finished result waits in the done state.
// A new request is taken while a finished result still waits in the output
// register. No clearing pass is needed after reset. Configuration writes take
// effect only while no buffer has been added yet.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top
#(
    parameter int MAX_BUFFERS       = 16,
    parameter int MAX_BUFFER_BLOCKS = 64
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fbpa_pkg::KIND_W-1:0]      kind,
    input  logic [fbpa_pkg::SIZE_W-1:0]      alloc_size,
    input  logic [fbpa_pkg::ADDR_W-1:0]      block_address,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fbpa_pkg::STATUS_W-1:0]    status,
    output logic [fbpa_pkg::ADDR_W-1:0]      granted_address
);
    import fbpa_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    fbpa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbpa_datapath
    #(
        .MAX_BUFFERS       (MAX_BUFFERS),
        .MAX_BUFFER_BLOCKS (MAX_BUFFER_BLOCKS)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (kind),
        .alloc_size      (alloc_size),
        .block_address   (block_address),
        .cmd             (cmd),
        .stat            (stat),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .granted_address (granted_address)
    );

endmodule
